>>> rtl/density_tone_map_rgb_defines.svh
// assertion helpers for the tone map block
`ifndef DENSITY_TONE_MAP_RGB_DEFINES_SVH
`define DENSITY_TONE_MAP_RGB_DEFINES_SVH

`ifndef SYNTHESIS
`define DTM_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");
`define DTM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");
`else
`define DTM_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define DTM_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

>>> rtl/dtm_rgb_pkg.sv
package dtm_rgb_pkg;

    localparam logic CMD_SCAN = 1'b0;
    localparam logic CMD_MAP  = 1'b1;

    localparam int TANH_STEPS = 48;
    localparam int DIFF_W     = 13;
    localparam logic [16:0] T_ONE = 17'd65536;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_TONE_A,
        ST_TONE_B,
        ST_FINISH
    } state_t;

    typedef enum logic [1:0] {
        CH_RED,
        CH_GREEN,
        CH_BLUE
    } chan_t;

    // tanh(k/8) in Q16
    function automatic logic [16:0] tanh_lut(input logic [5:0] k);
        logic [16:0] v;
        unique case (k)
            6'd0:  v = 17'd0;
            6'd1:  v = 17'd8150;
            6'd2:  v = 17'd16051;
            6'd3:  v = 17'd23485;
            6'd4:  v = 17'd30285;
            6'd5:  v = 17'd36346;
            6'd6:  v = 17'd41625;
            6'd7:  v = 17'd46131;
            6'd8:  v = 17'd49912;
            6'd9:  v = 17'd53038;
            6'd10: v = 17'd55593;
            6'd11: v = 17'd57660;
            6'd12: v = 17'd59320;
            6'd13: v = 17'd60643;
            6'd14: v = 17'd61694;
            6'd15: v = 17'd62524;
            6'd16: v = 17'd63179;
            6'd17: v = 17'd63693;
            6'd18: v = 17'd64096;
            6'd19: v = 17'd64412;
            6'd20: v = 17'd64659;
            6'd21: v = 17'd64852;
            6'd22: v = 17'd65003;
            6'd23: v = 17'd65120;
            6'd24: v = 17'd65212;
            6'd25: v = 17'd65283;
            6'd26: v = 17'd65339;
            6'd27: v = 17'd65383;
            6'd28: v = 17'd65417;
            6'd29: v = 17'd65443;
            6'd30: v = 17'd65464;
            6'd31: v = 17'd65480;
            6'd32: v = 17'd65492;
            6'd33: v = 17'd65502;
            6'd34: v = 17'd65509;
            6'd35: v = 17'd65515;
            6'd36: v = 17'd65520;
            6'd37: v = 17'd65523;
            6'd38: v = 17'd65526;
            6'd39: v = 17'd65528;
            6'd40: v = 17'd65530;
            6'd41: v = 17'd65531;
            6'd42: v = 17'd65532;
            6'd43: v = 17'd65533;
            6'd44: v = 17'd65534;
            6'd45: v = 17'd65534;
            6'd46: v = 17'd65535;
            6'd47: v = 17'd65535;
            default: v = T_ONE;
        endcase
        return v;
    endfunction

endpackage

>>> rtl/density_tone_map_rgb.sv
// scan items and map items with a zero divisor go straight to the finish state, from which the
// result is registered into the output; map items run the radix-2 divider loop and then 3 passes
// of the tanh unit, one per colour channel; no new item is taken until the last one is loaded out
// saturated ratios skip the divider
// rst_n is asynchronous active low: clears running maximum, normalizer, sequencer and out valid
`include "density_tone_map_rgb_defines.svh"

module density_tone_map_rgb
    import dtm_rgb_pkg::*;
#(
    parameter int COUNT_WIDTH     = 32,
    parameter int RATIO_FRAC_BITS = 12
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [31:0] normalizer,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        cmd,
    input  logic [31:0] bin_value,
    input  logic        first_of_frame,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  red,
    output logic [7:0]  green,
    output logic [7:0]  blue,
    output logic [31:0] frame_max,
    output logic        zero_divisor
);

    localparam int CNT_W = (COUNT_WIDTH < 32) ? COUNT_WIDTH : 32;
    localparam int F     = RATIO_FRAC_BITS;
    localparam int QW    = F + 4;
    localparam int XW    = F + 8;
    localparam int SS    = F - 3;
    localparam int IDXW  = XW - SS;
    localparam int NBITS = F + 3;
    localparam int BCW   = $clog2(NBITS);
    localparam int C33   = ((33 << F) + 50) / 100;
    localparam int C66   = ((66 << F) + 50) / 100;
    localparam logic [QW-1:0] SAT_Q = QW'(8) << F;

    state_t state_reg, state_next;
    chan_t  ch_reg, ch_next;

    logic [31:0]       normalizer_reg;
    logic [CNT_W-1:0]  running_max_reg;
    logic [CNT_W-1:0]  div_reg;
    logic [CNT_W-1:0]  rem_reg;
    logic [2:0]        dvd_reg;
    logic [QW-1:0]     q_reg;
    logic [BCW-1:0]    bit_cnt_reg;

    logic [16:0]       lo_reg;
    logic [DIFF_W-1:0] diff_reg;
    logic [SS-1:0]     frac_reg;
    logic              neg_reg;
    logic              full_reg;

    logic [7:0]        red_res_reg, green_res_reg, blue_res_reg;
    logic              zdiv_res_reg;

    logic              out_valid_reg;
    logic [7:0]        red_reg, green_reg, blue_reg;
    logic [31:0]       frame_max_reg;
    logic              zero_divisor_reg;

    logic              in_accept;
    logic              out_load;
    logic [CNT_W-1:0]  count;
    logic [CNT_W-1:0]  d_sel;
    logic [CNT_W-1:0]  count_hi;
    logic              d_zero;
    logic              sat;

    assign count    = bin_value[CNT_W-1:0];
    assign d_sel    = (|normalizer_reg) ? normalizer_reg[CNT_W-1:0] : running_max_reg;
    assign count_hi = count >> 3;
    assign d_zero   = ~|d_sel;
    // floor(n/8) >= d exactly when n >= 8d
    assign sat      = count_hi >= d_sel;
    assign in_accept = in_valid && !in_stall;

    // ---------------- sequencer ----------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (cmd == CMD_MAP && !d_zero)
                        state_next = sat ? ST_TONE_A : ST_DIV;
                    else
                        state_next = ST_FINISH;
                end
            end
            ST_DIV:
            begin
                if (bit_cnt_reg == BCW'(NBITS - 1))
                    state_next = ST_TONE_A;
            end
            ST_TONE_A:
                state_next = ST_TONE_B;
            ST_TONE_B:
            begin
                if (ch_reg == CH_BLUE)
                    state_next = ST_FINISH;
                else
                    state_next = ST_TONE_A;
            end
            ST_FINISH:
            begin
                if (!out_valid_reg || !out_stall)
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        in_stall = 1'b1;
        out_load = 1'b0;
        unique case (state_reg)
            ST_IDLE:   in_stall = 1'b0;
            ST_FINISH: out_load = !out_valid_reg || !out_stall;
            default:   in_stall = 1'b1;
        endcase
    end

    always_comb
    begin
        unique case (ch_reg)
            CH_RED:   ch_next = CH_GREEN;
            CH_GREEN: ch_next = CH_BLUE;
            default:  ch_next = CH_RED;
        endcase
    end

    // ---------------- divider step ----------------
    logic [CNT_W:0]   rem_sh;
    logic [CNT_W:0]   rem_sub;
    logic             q_bit;

    assign rem_sh  = {rem_reg, dvd_reg[2]};
    assign rem_sub = rem_sh - {1'b0, div_reg};
    assign q_bit   = rem_sh >= {1'b0, div_reg};

    // ---------------- tanh unit, first half ----------------
    logic signed [XW-1:0] q_s, y_g, y_b, x;
    logic        [XW-1:0] x_abs;
    logic        [IDXW-1:0] idx;
    logic        [16:0]   t_lo, t_hi;
    logic                 x_neg;

    assign q_s = signed'(XW'(q_reg));
    assign y_g = q_s - XW'(C33);
    assign y_b = q_s - XW'(C66);

    always_comb
    begin
        unique case (ch_reg)
            CH_RED:   x = q_s <<< 2;
            CH_GREEN: x = y_g <<< 2;
            default:  x = (y_b <<< 2) + (y_b <<< 1);
        endcase
    end

    assign x_neg = x[XW-1];
    assign x_abs = x_neg ? XW'(-x) : XW'(x);
    assign idx   = IDXW'(x_abs >> SS);
    assign t_lo  = tanh_lut(idx[5:0]);
    assign t_hi  = tanh_lut(idx[5:0] + 6'd1);

    // ---------------- tanh unit, second half ----------------
    logic [DIFF_W+SS-1:0] prod;
    logic [16:0]          t_val;
    logic [17:0]          v_half;
    logic [24:0]          sc_red;
    logic [25:0]          sc_half;
    logic [7:0]           byte_val;

    assign prod    = (DIFF_W + SS)'(diff_reg) * (DIFF_W + SS)'(frac_reg);
    assign t_val   = full_reg ? T_ONE : lo_reg + 17'(prod >> SS);
    assign v_half  = neg_reg ? (18'(T_ONE) - 18'(t_val)) : (18'(T_ONE) + 18'(t_val));
    // 255*t as a shift and subtract
    assign sc_red  = {t_val, 8'b0} - {8'b0, t_val};
    assign sc_half = {v_half, 8'b0} - {8'b0, v_half};
    assign byte_val = (ch_reg == CH_RED) ? sc_red[23:16] : sc_half[24:17];

    // ---------------- registers ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            ch_reg          <= CH_RED;
            bit_cnt_reg     <= '0;
            normalizer_reg  <= '0;
            running_max_reg <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready)
                normalizer_reg <= normalizer;
            if (in_accept && cmd == CMD_SCAN && (first_of_frame || count > running_max_reg))
                running_max_reg <= count;
            if (in_accept)
                ch_reg <= CH_RED;
            else if (state_reg == ST_TONE_B)
                ch_reg <= ch_next;
            if (in_accept)
                bit_cnt_reg <= '0;
            else if (state_reg == ST_DIV)
                bit_cnt_reg <= bit_cnt_reg + BCW'(1);
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            div_reg       <= d_sel;
            rem_reg       <= count_hi;
            dvd_reg       <= count[2:0];
            q_reg         <= sat ? SAT_Q : '0;
            red_res_reg   <= '0;
            green_res_reg <= '0;
            blue_res_reg  <= '0;
            zdiv_res_reg  <= (cmd == CMD_MAP) && d_zero;
        end
        else if (state_reg == ST_DIV)
        begin
            rem_reg <= q_bit ? rem_sub[CNT_W-1:0] : rem_sh[CNT_W-1:0];
            dvd_reg <= {dvd_reg[1:0], 1'b0};
            q_reg   <= {q_reg[QW-2:0], q_bit};
        end

        if (state_reg == ST_TONE_A)
        begin
            lo_reg   <= t_lo;
            diff_reg <= DIFF_W'(t_hi - t_lo);
            frac_reg <= x_abs[SS-1:0];
            neg_reg  <= x_neg;
            full_reg <= idx >= IDXW'(TANH_STEPS);
        end

        if (state_reg == ST_TONE_B)
        begin
            unique case (ch_reg)
                CH_RED:   red_res_reg   <= byte_val;
                CH_GREEN: green_res_reg <= byte_val;
                default:  blue_res_reg  <= byte_val;
            endcase
        end

        if (out_load)
        begin
            red_reg          <= red_res_reg;
            green_reg        <= green_res_reg;
            blue_reg         <= blue_res_reg;
            frame_max_reg    <= 32'(running_max_reg);
            zero_divisor_reg <= zdiv_res_reg;
        end
    end

    assign cfg_ready    = 1'b1;
    assign out_valid    = out_valid_reg;
    assign red          = red_reg;
    assign green        = green_reg;
    assign blue         = blue_reg;
    assign frame_max    = frame_max_reg;
    assign zero_divisor = zero_divisor_reg;

    // ---------------- checks ----------------
    `DTM_ASSERT_SAME(a_zdiv_black, clk, rst_n, out_valid && zero_divisor, red == 8'd0 && green == 8'd0 && blue == 8'd0)
    `DTM_ASSERT_SAME(a_ratio_bounded, clk, rst_n, state_reg == ST_TONE_A, q_reg <= SAT_Q)
    `DTM_ASSERT_NEXT(a_div_exit, clk, rst_n, state_reg == ST_DIV, state_reg == ST_DIV || state_reg == ST_TONE_A)
    `DTM_ASSERT_NEXT(a_frame_restart, clk, rst_n, in_accept && cmd == CMD_SCAN && first_of_frame, running_max_reg == $past(count))

endmodule
